// ===== design/bgl_pkg.sv =====
package bgl_pkg;

   // default operand width
   localparam int OPERAND_BITS_DEFAULT = 31;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_SCALE,
      ST_DIV,
      ST_MUL
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic gcd_step;
      logic scale;
      logic div_step;
      logic finish;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic any_zero;
      logic gcd_done;
      logic div_last;
   } sts_type;

endpackage

// ===== design/bgl_ctrl.sv =====
module bgl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  bgl_pkg::sts_type  sts,
   output bgl_pkg::cmd_type  cmd
);

   bgl_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic req_xfer;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != bgl_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bgl_pkg::ST_IDLE: begin
            if (req_valid) state_in = bgl_pkg::ST_GCD;
         end
         bgl_pkg::ST_GCD: begin
            priority if (sts.any_zero) state_in = bgl_pkg::ST_MUL;
            else if (sts.gcd_done)     state_in = bgl_pkg::ST_SCALE;
         end
         bgl_pkg::ST_SCALE: state_in = bgl_pkg::ST_DIV;
         bgl_pkg::ST_DIV: begin
            if (sts.div_last) state_in = bgl_pkg::ST_MUL;
         end
         bgl_pkg::ST_MUL: begin
            if (slot_free) state_in = bgl_pkg::ST_IDLE;
         end
         default: state_in = bgl_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         bgl_pkg::ST_IDLE:  cmd.load     = req_valid;
         bgl_pkg::ST_GCD:   cmd.gcd_step = !sts.any_zero && !sts.gcd_done;
         bgl_pkg::ST_SCALE: cmd.scale    = 1'b1;
         bgl_pkg::ST_DIV:   cmd.div_step = 1'b1;
         bgl_pkg::ST_MUL:   cmd.finish   = slot_free;
         default:           cmd          = '0;
      endcase
   end

   // result valid: set on finish, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bgl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an accepted request always starts the gcd phase
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == bgl_pkg::ST_GCD)
      else $error("request transfer did not start gcd phase");

   // last division step hands over to the multiply
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bgl_pkg::ST_DIV && sts.div_last) |=> state_ff == bgl_pkg::ST_MUL)
      else $error("division did not end in multiply");

   // finishing an item always presents a result
   a_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff && state_ff == bgl_pkg::ST_IDLE)
      else $error("finished item not presented");

endmodule

// ===== design/bgl_dp.sv =====
module bgl_dp #(
   parameter int OPERAND_BITS = bgl_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bgl_pkg::cmd_type            cmd,
   output bgl_pkg::sts_type            sts,
   input  logic [OPERAND_BITS-1:0]     req_first_operand,
   input  logic [OPERAND_BITS-1:0]     req_second_operand,
   output logic [2*OPERAND_BITS-1:0]   rsp_lcm_value,
   output logic                        rsp_zero_error
);

   localparam int W    = OPERAND_BITS;
   localparam int CNTW = $clog2(W);

   logic [W-1:0]      opa_ff, opb_ff;
   logic [W-1:0]      ga_ff, ga_in, gb_ff, gb_in;
   logic [CNTW-1:0]   twos_ff, twos_in;
   logic [W-1:0]      gcd_ff;
   logic [W-1:0]      rem_ff, rem_in;
   logic [W-1:0]      quo_ff, quo_in;
   logic [CNTW-1:0]   cnt_ff;
   logic [2*W-1:0]    lcm_ff;
   logic              err_ff;
   logic [W:0]        rem_shift;
   logic [W:0]        rem_diff;
   logic              any_zero;

   assign any_zero     = (opa_ff == '0) || (opb_ff == '0);
   assign sts.any_zero = any_zero;
   assign sts.gcd_done = (gb_ff == '0);
   assign sts.div_last = (cnt_ff == CNTW'(W - 1));

   // one binary gcd step
   always_comb begin
      ga_in   = ga_ff;
      gb_in   = gb_ff;
      twos_in = twos_ff;
      priority if (!ga_ff[0] && !gb_ff[0]) begin
         ga_in   = ga_ff >> 1;
         gb_in   = gb_ff >> 1;
         twos_in = twos_ff + CNTW'(1);
      end else if (!ga_ff[0]) begin
         ga_in = ga_ff >> 1;
      end else if (!gb_ff[0]) begin
         gb_in = gb_ff >> 1;
      end else if (ga_ff > gb_ff) begin
         ga_in = gb_ff;
         gb_in = ga_ff - gb_ff;
      end else begin
         gb_in = gb_ff - ga_ff;
      end
   end

   // restoring division step: quotient bits shift in behind the dividend
   always_comb begin
      rem_shift = {rem_ff, quo_ff[W-1]};
      rem_diff  = rem_shift - {1'b0, gcd_ff};
      if (!rem_diff[W]) begin
         rem_in = rem_diff[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b1};
      end else begin
         rem_in = rem_shift[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opa_ff  <= req_first_operand;
         opb_ff  <= req_second_operand;
         ga_ff   <= req_first_operand;
         gb_ff   <= req_second_operand;
         twos_ff <= '0;
      end
      if (cmd.gcd_step) begin
         ga_ff   <= ga_in;
         gb_ff   <= gb_in;
         twos_ff <= twos_in;
      end
      // restore shared twos and prime the divider with the second operand
      if (cmd.scale) begin
         gcd_ff <= ga_ff << twos_ff;
         rem_ff <= '0;
         quo_ff <= opb_ff;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + CNTW'(1);
      end
      // lcm = a * (b / gcd)
      if (cmd.finish) begin
         lcm_ff <= any_zero ? '0 : opa_ff * quo_ff;
         err_ff <= (opa_ff == '0) && (opb_ff == '0);
      end
   end

   assign rsp_lcm_value  = lcm_ff;
   assign rsp_zero_error = err_ff;

   // divisor is never zero once both operands are nonzero
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.scale && !any_zero) |=> gcd_ff != '0)
      else $error("gcd is zero for nonzero operands");

endmodule

// ===== design/binary_gcd_lcm_top.sv =====
// Channel  Ports                                        Transfer
// req      req_valid, req_stall, req_first_operand,     req_valid && !req_stall
//          req_second_operand
// rsp      rsp_valid, rsp_stall, rsp_lcm_value,         rsp_valid && !rsp_stall
//          rsp_zero_error
//
// One item at a time: a load step, then gcd steps (each shift drops one operand
// bit, each subtraction is followed by a shift), a scale step, OPERAND_BITS
// division steps, then the multiply into the output register; a zero operand
// skips from the gcd steps straight to the multiply. The multiply also waits
// while a stalled result still holds the output register.
// Reset is synchronous, active high; it clears the controller and the
// result valid. A stalled result is held while the next request is taken.
module binary_gcd_lcm_top #(
   parameter int OPERAND_BITS = bgl_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [OPERAND_BITS-1:0]     req_first_operand,
   input  logic [OPERAND_BITS-1:0]     req_second_operand,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2*OPERAND_BITS-1:0]   rsp_lcm_value,
   output logic                        rsp_zero_error
);

   bgl_pkg::cmd_type cmd;
   bgl_pkg::sts_type sts;

   bgl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bgl_dp #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .rsp_lcm_value      (rsp_lcm_value),
      .rsp_zero_error     (rsp_zero_error)
   );

endmodule
